// ===== sv/wahm_pkg.sv =====
// ----------------------------------------------------------------------------
// wahm_pkg
// Shared types and constants for the window average hysteresis alarm.
// ----------------------------------------------------------------------------
package wahm_pkg;

  localparam int unsigned FIELD_W   = 15;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned SLOT_REGS = 4;
  localparam int unsigned QUOT_W    = 16;
  localparam int unsigned DIV_BITS  = 4;

  localparam logic [FIELD_W-1:0] SAMPLE_MAX = 15'd25600;
  localparam logic [FIELD_W-1:0] LEVEL_MIN  = 15'd15360;
  localparam logic [FIELD_W-1:0] LEVEL_MAX  = 15'd23040;
  localparam logic [7:0]         WINDOW_RST = 8'd120;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR0   = 3'd2;

  localparam int unsigned LOG_BIT    = 30;
  localparam int unsigned REBOOT_BIT = 31;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_wr_t;

  typedef enum logic [1:0] {
    FR_IDLE = 2'b01,
    FR_SUM  = 2'b10
  } front_state_e;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_EVAL = 3'b100
  } back_state_e;

endpackage

// ===== sv/window_average_hysteresis_alarm.sv =====
// From sample accept to result valid, an item passes through the sum stage, the
//   queue, four divider steps of 4 quotient bits (skipped until the window has
//   filled) and evaluate. The front end accepts a new sample only after the last
//   sum is pushed; the back end pops only once the last item has been evaluated.
// Reset: control state, running sum and alarm flags clear at once; the ring
//   is not swept, its entries are masked until the window has filled.
// ----------------------------------------------------------------------------
// window_average_hysteresis_alarm
// Moving window average of utilization samples with hysteresis alarms.
// ----------------------------------------------------------------------------
module window_average_hysteresis_alarm #(
  parameter int unsigned MAX_WINDOW     = 128,
  parameter int unsigned MAX_THRESHOLDS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [14:0] sample_percent
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [14:0] average_percent, [18:15] asserted_mask,
                                      // [22:19] rise_mask, [26:23] fall_mask,
                                      // [30:27] log_rise_mask, [34:31] log_fall_mask,
                                      // [35] reboot_request
  output logic        m_axis_tuser    // [0] average_ready
);

  localparam int unsigned WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = $clog2(MAX_WINDOW * 25600 + 1);

  wahm_pkg::cfg_wr_t  cfg;
  logic               push, push_ready, pop, pop_valid;
  logic [SUM_W:0]     push_data, pop_data;
  logic [WIN_W-1:0]   win;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  wahm_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .WIN_W      (WIN_W),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .sample_i     (s_axis_tdata[14:0]),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data),
    .win_o        (win)
  );

  wahm_fifo #(
    .WIDTH (SUM_W + 1)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data)
  );

  wahm_back #(
    .MAX_THRESHOLDS (MAX_THRESHOLDS),
    .WIN_W          (WIN_W),
    .SUM_W          (SUM_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .win_i       (win),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_user_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== sv/wahm_fifo.sv =====
// ----------------------------------------------------------------------------
// wahm_fifo
// Two-entry queue between the sample front end and the alarm back end.
// ----------------------------------------------------------------------------
module wahm_fifo #(
  parameter int unsigned WIDTH = 23
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> push_ready_o) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> pop_valid_o) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

endmodule

// ===== sv/wahm_front.sv =====
// ----------------------------------------------------------------------------
// wahm_front
// Sample ring and running sum; forwards window state and sum to the queue.
// ----------------------------------------------------------------------------
module wahm_front #(
  parameter int unsigned MAX_WINDOW = 128,
  parameter int unsigned WIN_W      = 8,
  parameter int unsigned SUM_W      = 22
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wahm_pkg::cfg_wr_t             cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wahm_pkg::FIELD_W-1:0]  sample_i,
  output logic                          push_o,
  input  logic                          push_ready_i,
  output logic [SUM_W:0]                push_data_o,
  output logic [WIN_W-1:0]              win_o
);

  localparam int unsigned SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [wahm_pkg::FIELD_W-1:0] mem_q [MAX_WINDOW];
  logic [wahm_pkg::FIELD_W-1:0] rd_q, s_q, s_sat;
  logic [7:0]                   ws_q;
  logic [SLOT_W-1:0]            slot_q;
  logic [WIN_W-1:0]             slot_inc;
  logic                         full_q, old_ok_q;
  logic [SUM_W-1:0]             sum_q, sum_d;
  wahm_pkg::front_state_e       state_q;
  logic                         accept, win_wr;

  always_comb begin
    if (ws_q == 8'd0) begin
      win_o = WIN_W'(1);
    end else if (32'(ws_q) > MAX_WINDOW) begin
      win_o = WIN_W'(MAX_WINDOW);
    end else begin
      win_o = WIN_W'(ws_q);
    end
  end

  assign in_ready_o = (state_q == wahm_pkg::FR_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign s_sat      = (sample_i > wahm_pkg::SAMPLE_MAX) ? wahm_pkg::SAMPLE_MAX : sample_i;
  assign slot_inc   = WIN_W'(slot_q) + WIN_W'(1);
  assign win_wr     = cfg_i.valid && (cfg_i.index == wahm_pkg::REG_WINDOW);
  assign sum_d      = sum_q - (old_ok_q ? SUM_W'(rd_q) : SUM_W'(0)) + SUM_W'(s_q);
  assign push_o     = (state_q == wahm_pkg::FR_SUM) && push_ready_i;
  assign push_data_o = {full_q, sum_d};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q         <= mem_q[slot_q];
      mem_q[slot_q] <= s_sat;
      s_q          <= s_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wahm_pkg::FR_IDLE;
      ws_q     <= wahm_pkg::WINDOW_RST;
      slot_q   <= '0;
      full_q   <= 1'b0;
      old_ok_q <= 1'b0;
      sum_q    <= '0;
    end else begin
      if (win_wr) begin
        ws_q   <= cfg_i.data[7:0];
        slot_q <= '0;
        full_q <= 1'b0;
        sum_q  <= '0;
      end
      case (state_q)
        wahm_pkg::FR_IDLE: begin
          if (accept) begin
            old_ok_q <= full_q;
            if (slot_inc >= win_o) begin
              slot_q <= '0;
              full_q <= 1'b1;
            end else begin
              slot_q <= SLOT_W'(slot_inc);
            end
            state_q <= wahm_pkg::FR_SUM;
          end
        end
        wahm_pkg::FR_SUM: begin
          if (push_ready_i) begin
            sum_q   <= sum_d;
            state_q <= wahm_pkg::FR_IDLE;
          end
        end
        default: state_q <= wahm_pkg::FR_IDLE;
      endcase
    end
  end

  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WIN_W'(slot_q) < win_o) else $error("write slot beyond window");
  a_push_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> !push_o) else $error("double push for one item");
  a_accept_then_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == wahm_pkg::FR_SUM)) else $error("accept lost");

endmodule

// ===== sv/wahm_back.sv =====
// ----------------------------------------------------------------------------
// wahm_back
// Window average divider, threshold hysteresis and result register.
// ----------------------------------------------------------------------------
module wahm_back #(
  parameter int unsigned MAX_THRESHOLDS = 4,
  parameter int unsigned WIN_W          = 8,
  parameter int unsigned SUM_W          = 22
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wahm_pkg::cfg_wr_t cfg_i,
  input  logic [WIN_W-1:0]  win_i,
  input  logic              pop_valid_i,
  output logic              pop_o,
  input  logic [SUM_W:0]    pop_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_user_o,
  output logic [39:0]       out_data_o
);

  localparam int unsigned NT    = MAX_THRESHOLDS;
  localparam int unsigned CNT_W = $clog2(NT + 1);
  localparam int unsigned EXT_W = (SUM_W > WIN_W + wahm_pkg::QUOT_W) ? SUM_W
                                                                   : WIN_W + wahm_pkg::QUOT_W;
  localparam int unsigned STEPS = wahm_pkg::QUOT_W / wahm_pkg::DIV_BITS;
  localparam int unsigned STEP_W = $clog2(STEPS);
  localparam int unsigned FW = wahm_pkg::FIELD_W;
  localparam int unsigned MW = wahm_pkg::MASK_W;

  logic [wahm_pkg::CFG_DAT_W-1:0] thr_q [NT];
  logic [2:0]                     tcount_q;
  logic [NT-1:0]                  alarm_q, logged_q, alarm_d, logged_d;
  logic [NT-1:0]                  rise, fall, lrise, lfall, active;
  logic                           reboot;
  logic [CNT_W-1:0]               n_eff;
  wahm_pkg::back_state_e          state_q;
  logic                           full_q;
  logic [EXT_W-1:0]               rem_q, rem_d;
  logic [wahm_pkg::QUOT_W-1:0]    quot_q, quot_d;
  logic [STEP_W-1:0]              step_q;
  logic [FW-1:0]                  avg;
  logic                           load;

  logic                           ov_q, ready_q, reboot_q;
  logic [FW-1:0]                  avg_q;
  logic [MW-1:0]                  asrt_q, rise_q, fall_q, lrise_q, lfall_q;

  always_comb begin
    if (32'(tcount_q) > NT) begin
      n_eff = CNT_W'(NT);
    end else begin
      n_eff = CNT_W'(tcount_q);
    end
  end

  always_comb begin
    logic [EXT_W-1:0] dv;
    logic [4:0]       sh;
    rem_d  = rem_q;
    quot_d = quot_q;
    for (int i = 0; i < int'(wahm_pkg::DIV_BITS); i++) begin
      sh = 5'(wahm_pkg::QUOT_W - 1 - i) - 5'({step_q, 2'b00});
      dv = EXT_W'(win_i) << sh;
      if (rem_d >= dv) begin
        rem_d  = rem_d - dv;
        quot_d = quot_d | (wahm_pkg::QUOT_W'(1) << sh[3:0]);
      end
    end
  end

  assign avg = quot_q[FW-1:0];

  always_comb begin
    logic [FW-1:0] lvl, hyst;
    alarm_d  = alarm_q;
    logged_d = logged_q;
    rise     = '0;
    fall     = '0;
    lrise    = '0;
    lfall    = '0;
    reboot   = 1'b0;
    for (int k = 0; k < int'(NT); k++) begin
      active[k] = (CNT_W'(k) < n_eff);
      lvl  = thr_q[k][FW-1:0];
      hyst = thr_q[k][2*FW-1:FW];
      if (lvl < wahm_pkg::LEVEL_MIN) begin
        lvl = wahm_pkg::LEVEL_MIN;
      end
      if (lvl > wahm_pkg::LEVEL_MAX) begin
        lvl = wahm_pkg::LEVEL_MAX;
      end
      if (full_q && active[k]) begin
        if (!alarm_q[k] && (avg >= lvl)) begin
          alarm_d[k] = 1'b1;
          rise[k]    = 1'b1;
          if (thr_q[k][wahm_pkg::LOG_BIT] && !logged_q[k]) begin
            logged_d[k] = 1'b1;
            lrise[k]    = 1'b1;
          end
          if (thr_q[k][wahm_pkg::REBOOT_BIT]) begin
            reboot = 1'b1;
          end
        end
        if (alarm_q[k] && ((17'(avg) + 17'(hyst)) < 17'(lvl))) begin
          alarm_d[k] = 1'b0;
          fall[k]    = 1'b1;
          lfall[k]   = thr_q[k][wahm_pkg::LOG_BIT];
        end
      end
    end
  end

  function automatic logic [MW-1:0] low_mask(input logic [NT-1:0] m);
    logic [MW-1:0] r;
    r = '0;
    for (int i = 0; i < int'(MW); i++) begin
      if (i < int'(NT)) begin
        r[i] = m[i];
      end
    end
    return r;
  endfunction

  assign pop_o = (state_q == wahm_pkg::BK_IDLE) && pop_valid_i;
  assign load  = (state_q == wahm_pkg::BK_EVAL) && (!ov_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wahm_pkg::BK_IDLE;
      tcount_q <= '0;
      alarm_q  <= '0;
      logged_q <= '0;
      ov_q     <= 1'b0;
      full_q   <= 1'b0;
      step_q   <= '0;
      rem_q    <= '0;
      quot_q   <= '0;
      for (int k = 0; k < int'(NT); k++) begin
        thr_q[k] <= '0;
      end
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == wahm_pkg::REG_COUNT) begin
          tcount_q <= cfg_i.data[2:0];
        end
        for (int k = 0; k < int'(NT); k++) begin
          if (k < int'(wahm_pkg::SLOT_REGS) &&
              cfg_i.index == wahm_pkg::REG_THR0 + wahm_pkg::CFG_IDX_W'(k)) begin
            thr_q[k]    <= cfg_i.data;
            alarm_q[k]  <= 1'b0;
            logged_q[k] <= 1'b0;
          end
        end
      end
      if (load) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        wahm_pkg::BK_IDLE: begin
          if (pop_valid_i) begin
            full_q <= pop_data_i[SUM_W];
            rem_q  <= EXT_W'(pop_data_i[SUM_W-1:0]);
            quot_q <= '0;
            step_q <= '0;
            state_q <= pop_data_i[SUM_W] ? wahm_pkg::BK_DIV : wahm_pkg::BK_EVAL;
          end
        end
        wahm_pkg::BK_DIV: begin
          rem_q  <= rem_d;
          quot_q <= quot_d;
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(STEPS - 1)) begin
            state_q <= wahm_pkg::BK_EVAL;
          end
        end
        wahm_pkg::BK_EVAL: begin
          if (load) begin
            alarm_q  <= alarm_d;
            logged_q <= logged_d;
            state_q  <= wahm_pkg::BK_IDLE;
          end
        end
        default: state_q <= wahm_pkg::BK_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ready_q  <= full_q;
      avg_q    <= full_q ? avg : '0;
      asrt_q   <= low_mask(alarm_d & active);
      rise_q   <= low_mask(rise);
      fall_q   <= low_mask(fall);
      lrise_q  <= low_mask(lrise);
      lfall_q  <= low_mask(lfall);
      reboot_q <= reboot;
    end
  end

  assign out_valid_o = ov_q;
  assign out_user_o  = ready_q;
  assign out_data_o  = {4'b0000, reboot_q, lfall_q, lrise_q, fall_q, rise_q, asrt_q, avg_q};

  a_log_rise_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> ((lrise_q & ~rise_q) == '0 && (lfall_q & ~fall_q) == '0))
    else $error("log mask outside edge mask");
  a_edge_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> ((rise_q & fall_q) == '0)) else $error("rise and fall together");
  a_not_ready_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !ready_q) |-> (avg_q == '0 && rise_q == '0 && fall_q == '0 && !reboot_q))
    else $error("activity before window full");

endmodule
